// File: rtl/pcc_pkg.sv
// Shared widths, register codes and types for the pair Coulomb/contact force engine.
package pcc_pkg;

    localparam int Q_W       = 32;          // charges and constants, Q16.16
    localparam int RADIUS_W  = 31;
    localparam int RES_W     = 48;          // signed Q32.16 results
    localparam int DIST_W    = 32;
    localparam int NUM_W     = 3 * Q_W;     // |k| * |qa| * |qb|
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_COULOMB = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ELASTIC = 1'b1;

    localparam logic [Q_W-1:0]   CONST_RESET = 32'h0001_0000;
    localparam logic [RES_W-1:0] RES_POS_LIM = 48'h7FFF_FFFF_FFFF;
    localparam logic [RES_W-1:0] RES_NEG_LIM = 48'h8000_0000_0000;

    typedef struct packed {
        logic [RES_W-1:0] val;
        logic             sat;
    } sat_t;

endpackage

// File: rtl/pcc_if.sv
// Valid/ready channel interfaces for pair words and force result words.
interface pcc_in_if
    import pcc_pkg::*;
#(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] a_x;
    logic signed [COORD_WIDTH-1:0] a_y;
    logic signed [COORD_WIDTH-1:0] b_x;
    logic signed [COORD_WIDTH-1:0] b_y;
    logic [RADIUS_W-1:0]           a_radius;
    logic [RADIUS_W-1:0]           b_radius;
    logic signed [Q_W-1:0]         a_charge;
    logic signed [Q_W-1:0]         b_charge;

    modport source (
        output valid, a_x, a_y, b_x, b_y, a_radius, b_radius, a_charge, b_charge,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, b_x, b_y, a_radius, b_radius, a_charge, b_charge,
        output ready
    );
endinterface

interface pcc_out_if
    import pcc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [DIST_W-1:0]       pair_distance;
    logic                    in_contact;
    logic signed [RES_W-1:0] potential_energy;
    logic signed [RES_W-1:0] coulomb_force;
    logic signed [RES_W-1:0] elastic_force;
    logic                    saturated;

    modport source (
        output valid, pair_distance, in_contact, potential_energy, coulomb_force,
               elastic_force, saturated,
        input  ready
    );
    modport sink (
        input  valid, pair_distance, in_contact, potential_energy, coulomb_force,
               elastic_force, saturated,
        output ready
    );
endinterface

// File: rtl/pcc_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with a sideband word.
module pcc_sqrt_pipe
    import pcc_pkg::*;
#(
    parameter int ROOT_W = 34,
    parameter int SIDE_W = 1
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [2*ROOT_W-1:0]   rad,
    input  logic [SIDE_W-1:0]     side_in,
    output logic                  out_vld,
    output logic [ROOT_W-1:0]     root,
    output logic [SIDE_W-1:0]     side_out
);

    localparam int RAD_W = 2 * ROOT_W;
    localparam int REM_W = ROOT_W + 2;

    logic                 vld_reg  [0:ROOT_W-1];
    logic [RAD_W-1:0]     rad_reg  [0:ROOT_W-1];
    logic [RAD_W-1:0]     rad_next [0:ROOT_W-1];
    logic [REM_W-1:0]     rem_reg  [0:ROOT_W-1];
    logic [REM_W-1:0]     rem_next [0:ROOT_W-1];
    logic [ROOT_W-1:0]    root_reg [0:ROOT_W-1];
    logic [ROOT_W-1:0]    root_next[0:ROOT_W-1];
    logic [SIDE_W-1:0]    side_reg [0:ROOT_W-1];
    logic [SIDE_W-1:0]    side_next[0:ROOT_W-1];

    always_comb
    begin
        logic [RAD_W-1:0]  r_prev;
        logic [REM_W-1:0]  m_prev;
        logic [ROOT_W-1:0] q_prev;
        logic [REM_W-1:0]  rem2;
        logic [REM_W-1:0]  trial;
        logic              ge;
        for (int k = 0; k < ROOT_W; k++)
        begin
            if (k == 0)
            begin
                r_prev       = rad;
                m_prev       = '0;
                q_prev       = '0;
                side_next[k] = side_in;
            end
            else
            begin
                r_prev       = rad_reg[k-1];
                m_prev       = rem_reg[k-1];
                q_prev       = root_reg[k-1];
                side_next[k] = side_reg[k-1];
            end
            rem2         = {m_prev[REM_W-3:0], r_prev[RAD_W-1 -: 2]};
            trial        = {q_prev, 2'b01};
            ge           = (rem2 >= trial);
            rem_next[k]  = ge ? (rem2 - trial) : rem2;
            root_next[k] = {q_prev[ROOT_W-2:0], ge};
            rad_next[k]  = r_prev << 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                vld_reg[k] <= (k == 0) ? in_vld : vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < ROOT_W; k++)
            begin
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_vld  = vld_reg[ROOT_W-1];
    assign root     = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];

endmodule

// File: rtl/pcc_div_pipe.sv
// Pipelined restoring divider: 48 quotient bits, one per stage, plus overflow flag.
module pcc_div_pipe
    import pcc_pkg::*;
#(
    parameter int DEN_W  = 49,
    parameter int SIDE_W = 1
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_vld,
    output logic [RES_W-1:0]    quo,
    output logic                ovf,
    output logic [SIDE_W-1:0]   side_out
);

    localparam int HI_W  = NUM_W - RES_W;
    localparam int CMP_W = (DEN_W > HI_W) ? DEN_W : HI_W;
    localparam int NS    = RES_W + 1;   // setup stage plus one stage per bit

    logic                vld_reg  [0:NS-1];
    logic [DEN_W-1:0]    rem_reg  [0:NS-1];
    logic [DEN_W-1:0]    rem_next [0:NS-1];
    logic [DEN_W-1:0]    den_reg  [0:NS-1];
    logic [DEN_W-1:0]    den_next [0:NS-1];
    logic [RES_W-1:0]    low_reg  [0:NS-1];
    logic [RES_W-1:0]    low_next [0:NS-1];
    logic [RES_W-1:0]    quo_reg  [0:NS-1];
    logic [RES_W-1:0]    quo_next [0:NS-1];
    logic                ovf_reg  [0:NS-1];
    logic                ovf_next [0:NS-1];
    logic [SIDE_W-1:0]   side_reg [0:NS-1];
    logic [SIDE_W-1:0]   side_next[0:NS-1];

    always_comb
    begin
        logic [CMP_W-1:0] hi_ext;
        logic [DEN_W:0]   rem2;
        logic             ge;
        // setup: quotient beyond 48 bits when num >> 48 >= den
        hi_ext       = CMP_W'(num >> RES_W);
        ovf_next[0]  = (hi_ext >= CMP_W'(den));
        rem_next[0]  = DEN_W'(num >> RES_W);
        den_next[0]  = den;
        low_next[0]  = num[RES_W-1:0];
        quo_next[0]  = '0;
        side_next[0] = side_in;
        for (int k = 1; k < NS; k++)
        begin
            rem2         = {rem_reg[k-1], low_reg[k-1][RES_W-1]};
            ge           = (rem2 >= {1'b0, den_reg[k-1]});
            rem_next[k]  = ge ? DEN_W'(rem2 - {1'b0, den_reg[k-1]}) : DEN_W'(rem2);
            den_next[k]  = den_reg[k-1];
            low_next[k]  = low_reg[k-1] << 1;
            quo_next[k]  = {quo_reg[k-1][RES_W-2:0], ge};
            ovf_next[k]  = ovf_reg[k-1];
            side_next[k] = side_reg[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                vld_reg[k] <= (k == 0) ? in_vld : vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                den_reg[k]  <= den_next[k];
                low_reg[k]  <= low_next[k];
                quo_reg[k]  <= quo_next[k];
                ovf_reg[k]  <= ovf_next[k];
                side_reg[k] <= side_next[k];
            end
        end
    end

    assign out_vld  = vld_reg[NS-1];
    assign quo      = quo_reg[NS-1];
    assign ovf      = ovf_reg[NS-1];
    assign side_out = side_reg[NS-1];

endmodule

// File: rtl/pair_coulomb_contact_force.sv
// Pair Coulomb/contact force engine: throughput one pair word per cycle unless the
// output word stalls; the sqrt (one root bit per stage) and the two
// dividers (one quotient bit per stage) set the depth, not the rate.
// A stalled output word freezes the whole pipeline; nothing is dropped or repeated.
// Reset clears all valid bits and loads both constants with 1.0 (Q16.16).
module pair_coulomb_contact_force
    import pcc_pkg::*;
#(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 32
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [Q_W-1:0]       cfg_data,
    pcc_in_if.sink               pair_in,
    pcc_out_if.source            force_out
);

    localparam int DIFF_W     = COORD_WIDTH + 1;
    localparam int SQ_W       = 2 * DIFF_W;
    localparam int ROOT_W     = COORD_WIDTH + 2;
    localparam int RAD_W      = 2 * ROOT_W;
    localparam int RSUM_W     = RADIUS_W + 1;
    localparam int DF_W       = (ROOT_W > RSUM_W) ? ROOT_W : RSUM_W;
    localparam int PE_DW      = DF_W + FRAC_BITS;
    localparam int FC_DW      = 2 * DF_W;
    localparam int ELP_W      = Q_W + DF_W;
    localparam int EL_W       = ELP_W - FRAC_BITS;
    localparam int EL_CMP_W   = (EL_W > RES_W) ? EL_W : RES_W;
    localparam int SQ_SIDE_W  = 1 + RSUM_W + NUM_W;
    localparam int DV_SIDE_W  = 3 + DIST_W + ELP_W;

    // magnitude of a signed 32-bit value; -2^31 maps to 2^31
    function automatic logic [Q_W-1:0] mag32(input logic [Q_W-1:0] v);
        return v[Q_W-1] ? (~v + 1'b1) : v;
    endfunction

    // clamp a magnitude to the signed 48-bit range and apply the sign
    function automatic sat_t sat48(input logic [RES_W-1:0] m, input logic big,
                                   input logic neg);
        sat_t             r;
        logic [RES_W-1:0] lim;
        lim = neg ? RES_NEG_LIM : RES_POS_LIM;
        if (big || (m > lim))
        begin
            r.sat = 1'b1;
            r.val = lim;
        end
        else
        begin
            r.sat = 1'b0;
            r.val = m;
        end
        if (neg)
        begin
            r.val = ~r.val + 1'b1;
        end
        return r;
    endfunction

    // ---------------- configuration registers ----------------
    logic [Q_W-1:0] kc_reg;
    logic [Q_W-1:0] ke_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kc_reg <= CONST_RESET;
            ke_reg <= CONST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_COULOMB: kc_reg <= cfg_data;
                REG_ELASTIC: ke_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [Q_W-1:0] kc_mag;
    logic [Q_W-1:0] ke_mag;
    assign kc_mag = mag32(kc_reg);
    assign ke_mag = mag32(ke_reg);

    // Global advance: every stage moves when the output word is empty or taken.
    logic en;
    logic out_vld_reg;
    assign en            = !out_vld_reg || force_out.ready;
    assign pair_in.ready = en;

    // ---------------- S1: differences, radius sum, charge magnitudes ----------------
    logic              s1_vld_reg;
    logic [DIFF_W-1:0] s1_dx_reg, s1_dy_reg;
    logic [RSUM_W-1:0] s1_rsum_reg;
    logic [Q_W-1:0]    s1_qa_reg, s1_qb_reg;
    logic              s1_neg_reg;

    // ---------------- S2: |dx|, |dy|, |k|*|qa| ----------------
    logic              s2_vld_reg;
    logic [DIFF_W-1:0] s2_ax_reg, s2_ay_reg;
    logic [2*Q_W-1:0]  s2_kq_reg;
    logic [Q_W-1:0]    s2_qb_reg;
    logic [RSUM_W-1:0] s2_rsum_reg;
    logic              s2_neg_reg;

    // ---------------- S3: squares and partial products of k*qa*qb ----------------
    logic              s3_vld_reg;
    logic [SQ_W-1:0]   s3_sqx_reg, s3_sqy_reg;
    logic [2*Q_W-1:0]  s3_plo_reg, s3_phi_reg;
    logic [RSUM_W-1:0] s3_rsum_reg;
    logic              s3_neg_reg;

    // ---------------- S4: radicand and full numerator ----------------
    logic              s4_vld_reg;
    logic [RAD_W-1:0]  s4_rad_reg;
    logic [NUM_W-1:0]  s4_num_reg;
    logic [RSUM_W-1:0] s4_rsum_reg;
    logic              s4_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= pair_in.valid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dx_reg   <= {pair_in.a_x[COORD_WIDTH-1], pair_in.a_x}
                         - {pair_in.b_x[COORD_WIDTH-1], pair_in.b_x};
            s1_dy_reg   <= {pair_in.a_y[COORD_WIDTH-1], pair_in.a_y}
                         - {pair_in.b_y[COORD_WIDTH-1], pair_in.b_y};
            s1_rsum_reg <= {1'b0, pair_in.a_radius} + {1'b0, pair_in.b_radius};
            s1_qa_reg   <= mag32(pair_in.a_charge);
            s1_qb_reg   <= mag32(pair_in.b_charge);
            s1_neg_reg  <= kc_reg[Q_W-1] ^ pair_in.a_charge[Q_W-1] ^ pair_in.b_charge[Q_W-1];

            s2_ax_reg   <= s1_dx_reg[DIFF_W-1] ? (~s1_dx_reg + 1'b1) : s1_dx_reg;
            s2_ay_reg   <= s1_dy_reg[DIFF_W-1] ? (~s1_dy_reg + 1'b1) : s1_dy_reg;
            s2_kq_reg   <= (2*Q_W)'(kc_mag) * (2*Q_W)'(s1_qa_reg);
            s2_qb_reg   <= s1_qb_reg;
            s2_rsum_reg <= s1_rsum_reg;
            s2_neg_reg  <= s1_neg_reg;

            s3_sqx_reg  <= SQ_W'(s2_ax_reg) * SQ_W'(s2_ax_reg);
            s3_sqy_reg  <= SQ_W'(s2_ay_reg) * SQ_W'(s2_ay_reg);
            s3_plo_reg  <= (2*Q_W)'(s2_kq_reg[Q_W-1:0]) * (2*Q_W)'(s2_qb_reg);
            s3_phi_reg  <= (2*Q_W)'(s2_kq_reg[2*Q_W-1:Q_W]) * (2*Q_W)'(s2_qb_reg);
            s3_rsum_reg <= s2_rsum_reg;
            s3_neg_reg  <= s2_neg_reg;

            s4_rad_reg  <= RAD_W'(s3_sqx_reg) + RAD_W'(s3_sqy_reg);
            s4_num_reg  <= (NUM_W'(s3_phi_reg) << Q_W) + NUM_W'(s3_plo_reg);
            s4_rsum_reg <= s3_rsum_reg;
            s4_neg_reg  <= s3_neg_reg;
        end
    end

    // ---------------- square root: floor(sqrt(dx^2 + dy^2)) ----------------
    logic                 sq_vld;
    logic [ROOT_W-1:0]    sq_root;
    logic [SQ_SIDE_W-1:0] sq_side;

    pcc_sqrt_pipe #(
        .ROOT_W (ROOT_W),
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s4_vld_reg),
        .rad      (s4_rad_reg),
        .side_in  ({s4_neg_reg, s4_rsum_reg, s4_num_reg}),
        .out_vld  (sq_vld),
        .root     (sq_root),
        .side_out (sq_side)
    );

    logic              sq_neg;
    logic [RSUM_W-1:0] sq_rsum;
    logic [NUM_W-1:0]  sq_num;
    logic [DF_W-1:0]   d_ext, rs_ext;
    logic              contact, dist_big;

    assign sq_neg   = sq_side[SQ_SIDE_W-1];
    assign sq_rsum  = sq_side[NUM_W +: RSUM_W];
    assign sq_num   = sq_side[NUM_W-1:0];
    assign d_ext    = DF_W'(sq_root);
    assign rs_ext   = DF_W'(sq_rsum);
    assign contact  = (d_ext < rs_ext);
    assign dist_big = ((sq_root >> DIST_W) != '0);

    // ---------------- S5: contact test, effective distance ----------------
    logic              s5_vld_reg;
    logic [DF_W-1:0]   s5_df_reg;
    logic              s5_contact_reg;
    logic [DIST_W-1:0] s5_dist_reg;
    logic              s5_dflag_reg;
    logic [NUM_W-1:0]  s5_num_reg;
    logic              s5_neg_reg;

    // ---------------- S6: divisors and elastic product ----------------
    logic              s6_vld_reg;
    logic [PE_DW-1:0]  s6_den_pe_reg;
    logic [FC_DW-1:0]  s6_den_fc_reg;
    logic [ELP_W-1:0]  s6_elp_reg;
    logic              s6_dfz_reg;
    logic              s6_contact_reg;
    logic [DIST_W-1:0] s6_dist_reg;
    logic              s6_dflag_reg;
    logic [NUM_W-1:0]  s6_num_reg;
    logic              s6_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s5_vld_reg <= sq_vld;
            s6_vld_reg <= s5_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_df_reg      <= contact ? rs_ext : d_ext;
            s5_contact_reg <= contact;
            s5_dist_reg    <= dist_big ? '1 : DIST_W'(sq_root);
            s5_dflag_reg   <= dist_big;
            s5_num_reg     <= sq_num;
            s5_neg_reg     <= sq_neg;

            s6_den_pe_reg  <= PE_DW'(s5_df_reg) << FRAC_BITS;
            s6_den_fc_reg  <= FC_DW'(s5_df_reg) * FC_DW'(s5_df_reg);
            s6_elp_reg     <= ELP_W'(ke_mag) * ELP_W'(s5_df_reg);
            s6_dfz_reg     <= (s5_df_reg == '0);
            s6_contact_reg <= s5_contact_reg;
            s6_dist_reg    <= s5_dist_reg;
            s6_dflag_reg   <= s5_dflag_reg;
            s6_num_reg     <= s5_num_reg;
            s6_neg_reg     <= s5_neg_reg;
        end
    end

    // ---------------- dividers: pe = num/(df<<F), fc = num/df^2 ----------------
    logic                 pe_vld, pe_ovf;
    logic [RES_W-1:0]     pe_q;
    logic [DV_SIDE_W-1:0] dv_side;
    logic                 fc_vld, fc_ovf;
    logic [RES_W-1:0]     fc_q;
    logic                 fc_side;

    pcc_div_pipe #(
        .DEN_W  (PE_DW),
        .SIDE_W (DV_SIDE_W)
    ) u_div_pe (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s6_vld_reg),
        .num      (s6_num_reg),
        .den      (s6_den_pe_reg),
        .side_in  ({s6_dfz_reg, s6_dflag_reg, s6_contact_reg, s6_dist_reg, s6_elp_reg}),
        .out_vld  (pe_vld),
        .quo      (pe_q),
        .ovf      (pe_ovf),
        .side_out (dv_side)
    );

    pcc_div_pipe #(
        .DEN_W  (FC_DW),
        .SIDE_W (1)
    ) u_div_fc (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s6_vld_reg),
        .num      (s6_num_reg),
        .den      (s6_den_fc_reg),
        .side_in  (s6_neg_reg),
        .out_vld  (fc_vld),
        .quo      (fc_q),
        .ovf      (fc_ovf),
        .side_out (fc_side)
    );

    // ---------------- final: sign, saturation, flags ----------------
    logic                dv_dfz, dv_dflag, dv_contact;
    logic [DIST_W-1:0]   dv_dist;
    logic [ELP_W-1:0]    dv_elp;
    logic                pe_nz, fc_nz;
    logic [EL_CMP_W-1:0] el_ext;
    logic                el_big;
    sat_t                pe_r, fc_r, el_r;

    assign dv_dfz     = dv_side[DV_SIDE_W-1];
    assign dv_dflag   = dv_side[DV_SIDE_W-2];
    assign dv_contact = dv_side[DV_SIDE_W-3];
    assign dv_dist    = dv_side[ELP_W +: DIST_W];
    assign dv_elp     = dv_side[ELP_W-1:0];

    // zero effective distance forces both Coulomb terms to zero
    assign pe_nz  = !dv_dfz && (pe_ovf || (pe_q != '0));
    assign fc_nz  = !dv_dfz && (fc_ovf || (fc_q != '0));
    assign pe_r   = sat48(dv_dfz ? '0 : pe_q, !dv_dfz && pe_ovf, fc_side && pe_nz);
    assign fc_r   = sat48(dv_dfz ? '0 : fc_q, !dv_dfz && fc_ovf, fc_side && fc_nz);

    assign el_ext = EL_CMP_W'(dv_elp >> FRAC_BITS);
    assign el_big = ((el_ext >> RES_W) != '0);
    assign el_r   = sat48(el_ext[RES_W-1:0], el_big, ke_reg[Q_W-1] && (el_ext != '0));

    // ---------------- output word register ----------------
    logic [DIST_W-1:0] dist_reg;
    logic              contact_reg;
    logic [RES_W-1:0]  pe_reg, fc_reg, el_reg;
    logic              sat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= pe_vld && fc_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dist_reg    <= dv_dist;
            contact_reg <= dv_contact;
            pe_reg      <= pe_r.val;
            fc_reg      <= fc_r.val;
            el_reg      <= el_r.val;
            sat_reg     <= dv_dflag || dv_dfz || pe_r.sat || fc_r.sat || el_r.sat;
        end
    end

    assign force_out.valid            = out_vld_reg;
    assign force_out.pair_distance    = dist_reg;
    assign force_out.in_contact       = contact_reg;
    assign force_out.potential_energy = pe_reg;
    assign force_out.coulomb_force    = fc_reg;
    assign force_out.elastic_force    = el_reg;
    assign force_out.saturated        = sat_reg;

endmodule

// File: dv/tb.sv
// Self-checking testbench for the pair Coulomb/contact force engine.
module tb;
    import pcc_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int LATENCY     = COORD_WIDTH + 58;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0]         a_x;
        logic [31:0]         a_y;
        logic [31:0]         b_x;
        logic [31:0]         b_y;
        logic [RADIUS_W-1:0] a_radius;
        logic [RADIUS_W-1:0] b_radius;
        logic [Q_W-1:0]      a_charge;
        logic [Q_W-1:0]      b_charge;
    } pair_t;

    typedef struct packed {
        logic [DIST_W-1:0] pair_distance;
        logic              in_contact;
        logic [RES_W-1:0]  potential_energy;
        logic [RES_W-1:0]  coulomb_force;
        logic [RES_W-1:0]  elastic_force;
        logic              saturated;
    } force_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [Q_W-1:0] cfg_data;

    pcc_in_if #(.COORD_WIDTH(COORD_WIDTH)) pair_in ();
    pcc_out_if force_out ();

    pair_coulomb_contact_force #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pair_in   (pair_in),
        .force_out (force_out)
    );

    // predictor's copy of the two constants
    logic [Q_W-1:0] coulomb_k;
    logic [Q_W-1:0] elastic_k;

    force_t expected_forces[$];
    int     error_count;
    int     cycle_count;
    bit     idle_enabled;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // magnitude of a 32-bit two's complement value, widened
    function automatic logic [127:0] mag32(logic [31:0] v);
        logic [31:0] m;
        m = v[31] ? (~v + 32'd1) : v;
        return 128'(m);
    endfunction

    // clamp a magnitude to the signed 48-bit range, then apply the sign
    function automatic logic [RES_W-1:0] clamp48(logic [127:0] m, bit neg, inout bit flag);
        logic [127:0] lim;
        logic [127:0] v;
        lim = neg ? (128'd1 << 47) : (128'd1 << 47) - 128'd1;
        if (m > lim)
        begin
            v = lim;
            flag = 1'b1;
        end
        else
            v = m;
        return neg ? RES_W'(-v) : RES_W'(v);
    endfunction

    function automatic force_t predict_forces(pair_t p);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [127:0] ax, ay, sq, root, trial, rsum, df, num, pe, fc, el;
        bit flag;
        bit contact;
        bit neg_c;
        bit neg_e;
        force_t r;
        flag = 1'b0;
        dx = $signed({p.a_x[31], p.a_x}) - $signed({p.b_x[31], p.b_x});
        dy = $signed({p.a_y[31], p.a_y}) - $signed({p.b_y[31], p.b_y});
        ax = dx[32] ? 128'(-dx) & {95'd0, 33'h1_FFFF_FFFF} : 128'(dx);
        ay = dy[32] ? 128'(-dy) & {95'd0, 33'h1_FFFF_FFFF} : 128'(dy);
        sq = ax * ax + ay * ay;
        // bitwise floor square root
        root = 128'd0;
        for (int b = 40; b >= 0; b--)
        begin
            trial = root | (128'd1 << b);
            if (trial * trial <= sq)
                root = trial;
        end
        rsum = 128'(p.a_radius) + 128'(p.b_radius);
        contact = root < rsum;
        df = contact ? rsum : root;
        if (root > 128'hFFFF_FFFF)
        begin
            r.pair_distance = '1;
            flag = 1'b1;
        end
        else
            r.pair_distance = root[31:0];
        neg_c = coulomb_k[31] ^ p.a_charge[31] ^ p.b_charge[31];
        pe = 128'd0;
        fc = 128'd0;
        if (df == 128'd0)
            flag = 1'b1;    // zero effective distance: no Coulomb terms
        else
        begin
            num = mag32(coulomb_k) * mag32(p.a_charge) * mag32(p.b_charge);
            pe = num / (df << FRAC_BITS);
            fc = num / (df * df);
        end
        el = (mag32(elastic_k) * df) >> FRAC_BITS;
        neg_e = elastic_k[31] && el != 128'd0;
        r.in_contact = contact;
        r.potential_energy = clamp48(pe, neg_c && pe != 128'd0, flag);
        r.coulomb_force = clamp48(fc, neg_c && fc != 128'd0, flag);
        r.elastic_force = clamp48(el, neg_e, flag);
        r.saturated = flag;
        return r;
    endfunction

    // --- driving ---------------------------------------------------------

    task automatic send_pair(pair_t p);
        while (idle_enabled && $urandom_range(99) < 22)
        begin
            pair_in.valid = 1'b0;
            @(negedge clk);
        end
        pair_in.valid    = 1'b1;
        pair_in.a_x      = p.a_x;
        pair_in.a_y      = p.a_y;
        pair_in.b_x      = p.b_x;
        pair_in.b_y      = p.b_y;
        pair_in.a_radius = p.a_radius;
        pair_in.b_radius = p.b_radius;
        pair_in.a_charge = p.a_charge;
        pair_in.b_charge = p.b_charge;
        forever
        begin
            @(posedge clk);
            if (pair_in.ready)
                break;
        end
        expected_forces.push_back(predict_forces(p));
        @(negedge clk);
    endtask

    // wait for the pipeline to drain, then write one constant
    task automatic write_constant(logic [CFG_IDX_W-1:0] idx, logic [Q_W-1:0] value);
        pair_in.valid = 1'b0;
        while (expected_forces.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_COULOMB)
            coulomb_k = value;
        else
            elastic_k = value;
    endtask

    function automatic pair_t make_pair(int unsigned ax, int unsigned ay, int unsigned bx,
                                        int unsigned by, int unsigned ra, int unsigned rb,
                                        int unsigned qa, int unsigned qb);
        pair_t p;
        p.a_x = ax;
        p.a_y = ay;
        p.b_x = bx;
        p.b_y = by;
        p.a_radius = ra[30:0];
        p.b_radius = rb[30:0];
        p.a_charge = qa;
        p.b_charge = qb;
        return p;
    endfunction

    // mostly near pairs so contact and no-contact both show up; some full range
    function automatic pair_t random_pair();
        pair_t p;
        int unsigned mode;
        int unsigned span;
        mode = $urandom_range(99);
        p = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom);
        if (mode < 60)
        begin
            span = 32'h1 << $urandom_range(24, 4);
            p.b_x = p.a_x + ($urandom % span) - span / 2;
            p.b_y = p.a_y + ($urandom % span) - span / 2;
            p.a_radius = $urandom % span;
            p.b_radius = $urandom % span;
            if ($urandom_range(1))
            begin
                p.a_charge = $signed(p.a_charge) >>> $urandom_range(24, 8);
                p.b_charge = $signed(p.b_charge) >>> $urandom_range(24, 8);
            end
        end
        else if (mode < 65)
        begin
            // coincident centers
            p.b_x = p.a_x;
            p.b_y = p.a_y;
            if ($urandom_range(1))
            begin
                p.a_radius = '0;
                p.b_radius = '0;
            end
        end
        return p;
    endfunction

    // --- checking --------------------------------------------------------

    always @(posedge clk)
    begin
        force_t got;
        force_t want;
        if (rst_n && force_out.valid && force_out.ready)
        begin
            got.pair_distance    = force_out.pair_distance;
            got.in_contact       = force_out.in_contact;
            got.potential_energy = force_out.potential_energy;
            got.coulomb_force    = force_out.coulomb_force;
            got.elastic_force    = force_out.elastic_force;
            got.saturated        = force_out.saturated;
            if (expected_forces.size() == 0)
            begin
                $display("%0t: unexpected force word %h", $time, got);
                error_count++;
            end
            else
            begin
                want = expected_forces.pop_front();
                if (got.pair_distance !== want.pair_distance)
                begin
                    $display("%0t: pair_distance exp %h got %h", $time,
                             want.pair_distance, got.pair_distance);
                    error_count++;
                end
                if (got.in_contact !== want.in_contact)
                begin
                    $display("%0t: in_contact exp %b got %b", $time,
                             want.in_contact, got.in_contact);
                    error_count++;
                end
                if (got.potential_energy !== want.potential_energy)
                begin
                    $display("%0t: potential_energy exp %h got %h", $time,
                             want.potential_energy, got.potential_energy);
                    error_count++;
                end
                if (got.coulomb_force !== want.coulomb_force)
                begin
                    $display("%0t: coulomb_force exp %h got %h", $time,
                             want.coulomb_force, got.coulomb_force);
                    error_count++;
                end
                if (got.elastic_force !== want.elastic_force)
                begin
                    $display("%0t: elastic_force exp %h got %h", $time,
                             want.elastic_force, got.elastic_force);
                    error_count++;
                end
                if (got.saturated !== want.saturated)
                begin
                    $display("%0t: saturated exp %b got %b", $time,
                             want.saturated, got.saturated);
                    error_count++;
                end
            end
        end
    end

    // random backpressure on the result side
    always @(negedge clk)
    begin
        force_out.ready <= !idle_enabled || $urandom_range(99) >= 22;
    end

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL pair_coulomb_contact_force");
            $finish;
        end
    end

    // --- tests -----------------------------------------------------------

    // edge cases, first run under the reset constants (k = ke = 1.0)
    task automatic test_directed();
        // coincident centers, zero radii: zero effective distance
        send_pair(make_pair(0, 0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000));
        send_pair(make_pair(32'h1234_5678, 32'h8000_0000, 32'h1234_5678, 32'h8000_0000,
                            0, 0, 32'hFFFF_FFFF, 32'h8000_0000));
        // coincident but with radii: contact with df = radius sum
        send_pair(make_pair(5, 5, 5, 5, 32'h0001_0000, 32'h0000_8000,
                            32'h0002_0000, 32'hFFFE_0000));
        // opposite corners: distance beyond 32 bits
        send_pair(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send_pair(make_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            0, 0, 32'h8000_0000, 32'h8000_0000));
        // 3-4-5 triangle, exact root, no contact
        send_pair(make_pair(32'h0003_0000, 32'h0004_0000, 0, 0, 32'h0001_0000,
                            32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        // distance equal to the radius sum: not in contact
        send_pair(make_pair(32'h0003_0000, 32'h0004_0000, 0, 0, 32'h0002_0000,
                            32'h0003_0000, 32'h0001_0000, 32'hFFFF_0000));
        // just inside contact
        send_pair(make_pair(32'h0003_0000, 32'h0004_0000, 0, 0, 32'h0002_0000,
                            32'h0003_0001, 32'h0001_0000, 32'hFFFF_0000));
        // tiny distance, huge charges: Coulomb saturation both signs
        send_pair(make_pair(1, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_pair(make_pair(0, 1, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000));
        // one zero charge
        send_pair(make_pair(32'h0010_0000, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        // radii at full scale
        send_pair(make_pair(0, 0, 32'h0000_0100, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h0001_0000, 32'h0001_0000));
        // all-ones pattern and alternating bits
        send_pair(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                            32'h5555_5555, 32'h2AAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555));
        send_pair(make_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 0,
                            32'h2AAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA));
        // tiny quotients that truncate to zero
        send_pair(make_pair(32'h7000_0000, 0, 32'h9000_0000, 0, 0, 0, 1, 1));
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_pair(random_pair());
    endtask

    // a run at full rate on both sides
    task automatic test_back_to_back(int count);
        idle_enabled = 1'b0;
        test_random(count);
        idle_enabled = 1'b1;
    endtask

    // several constant settings, the extremes among them
    task automatic test_constants();
        write_constant(REG_COULOMB, 32'h7FFF_FFFF);
        write_constant(REG_ELASTIC, 32'h8000_0000);
        test_directed();
        test_random(150);
        write_constant(REG_COULOMB, 32'h8000_0000);
        write_constant(REG_ELASTIC, 32'h7FFF_FFFF);
        test_random(150);
        write_constant(REG_COULOMB, 32'h0000_0000);
        write_constant(REG_ELASTIC, 32'h0000_0000);
        test_random(60);
        write_constant(REG_COULOMB, 32'hFFFF_FFFF);
        write_constant(REG_ELASTIC, 32'h0000_0001);
        test_random(60);
        for (int s = 0; s < 3; s++)
        begin
            write_constant(REG_COULOMB, $urandom);
            write_constant(REG_ELASTIC, $urandom);
            test_random(100);
        end
        write_constant(REG_COULOMB, CONST_RESET);
        write_constant(REG_ELASTIC, CONST_RESET);
        test_random(100);
    endtask

    initial
    begin
        error_count     = 0;
        cycle_count     = 0;
        idle_enabled    = 1'b1;
        coulomb_k       = CONST_RESET;
        elastic_k       = CONST_RESET;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_COULOMB;
        cfg_data        = '0;
        pair_in.valid   = 1'b0;
        pair_in.a_x     = '0;
        pair_in.a_y     = '0;
        pair_in.b_x     = '0;
        pair_in.b_y     = '0;
        pair_in.a_radius = '0;
        pair_in.b_radius = '0;
        pair_in.a_charge = '0;
        pair_in.b_charge = '0;
        force_out.ready = 1'b1;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(200);
        test_back_to_back(150);
        test_constants();

        pair_in.valid = 1'b0;
        while (expected_forces.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 20) @(negedge clk);
        if (error_count == 0)
            $display("PASS pair_coulomb_contact_force");
        else
            $display("FAIL pair_coulomb_contact_force");
        $finish;
    end

endmodule
